@@ hw/rtl/bfa_pkg.sv @@
// ---------------------------------------------------------------------------
// bfa_pkg
// Shared sizes, request kinds and status codes of the bitmap frame allocator.
// ---------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAMES    = 4096;
  localparam int WORD_W    = 64;
  localparam int MAP_WORDS = FRAMES / WORD_W;
  localparam int WORD_AW   = $clog2(MAP_WORDS);
  localparam int OFF_W     = $clog2(WORD_W);
  localparam int OFFC_W    = OFF_W + 1;
  localparam int FRAME_W   = 12;
  localparam int CNT_W     = 13;

  localparam logic [CNT_W-1:0] TOTAL_RST = CNT_W'(FRAMES);

  localparam logic [2:0] KIND_ALLOC_ONE = 3'd0;
  localparam logic [2:0] KIND_ALLOC_RUN = 3'd1;
  localparam logic [2:0] KIND_FREE_ONE  = 3'd2;
  localparam logic [2:0] KIND_FREE_RUN  = 3'd3;
  localparam logic [2:0] KIND_MARK_USE  = 3'd4;
  localparam logic [2:0] KIND_MARK_RESV = 3'd5;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

endpackage

@@ hw/rtl/bitmap_frame_allocator_top.sv @@
// Each bitmap word visited takes a read state, then an evaluate state; the result register is
// loaded last, and requests settled at decode go to it directly. Allocate one visits at most
// W+1 words, W = ceil(total/64); allocate run scans up to W words and then rewrites the words
// of the run; free and mark touch only the words of the range. Throughput is one request at a
// time, and the single-port bitmap memory is read a 64-bit word at a time. Reset is synchronous;
// per-word valid bits make the whole bitmap read as reserved at once, so the block is ready at once.
// ---------------------------------------------------------------------------
// bitmap_frame_allocator_top
// Physical frame allocator over a free bitmap (1 = free) with a next-fit hint
// and saturating free and used counts. A small sequencer walks the bitmap one
// 64-bit word at a time through a shared word evaluation unit.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator_top
  import bfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [FRAME_W-1:0] start_frame,
  input  logic [CNT_W-1:0]   frame_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [FRAME_W-1:0] result_frame,
  output logic [CNT_W-1:0]   free_total,
  output logic [CNT_W-1:0]   used_total,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EV, S_OUT} state_t;

  // Mask with every bit below n set; n may reach the word width.
  function automatic logic [WORD_W-1:0] lo_bits(input logic [OFFC_W-1:0] n);
    return ~({WORD_W{1'b1}} << n);
  endfunction

  // Offset of frame bound x within the word starting at frame b, clamped to 0..64.
  function automatic logic [OFFC_W-1:0] rel_off(input logic [CNT_W-1:0] x,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W-1:0] d;
    d = x - b;
    if (x <= b) return '0;
    else if (d >= CNT_W'(WORD_W)) return OFFC_W'(WORD_W);
    else return d[OFFC_W-1:0];
  endfunction

  // Lowest set bit, or the word width when there is none.
  function automatic logic [OFFC_W-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [OFFC_W-1:0] r;
    r = OFFC_W'(WORD_W);
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (v[j]) r = OFFC_W'(j);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c,
                                               input logic [CNT_W-1:0] n,
                                               input logic [CNT_W-1:0] top);
    if (c >= top) return c;
    else if (top - c < n) return top;
    else return c + n;
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] c,
                                               input logic [CNT_W-1:0] n);
    return (c < n) ? '0 : c - n;
  endfunction

  // The bitmap memory: one 64-bit word per entry, registered read data.
  logic [WORD_W-1:0]    free_map [MAP_WORDS];
  logic [MAP_WORDS-1:0] word_ok;
  logic [WORD_W-1:0]    mem_q;
  logic                 vld_q;
  logic                 wr_en;
  logic [WORD_W-1:0]    wr_data;

  // Control and request registers.
  state_t             state;
  logic [WORD_AW-1:0] cur;
  logic               phase;
  logic               clearing;
  logic [CNT_W-1:0]   carry;
  logic [2:0]         op_kind;
  logic [FRAME_W-1:0] op_start;
  logic [CNT_W-1:0]   op_need;
  logic [CNT_W-1:0]   op_lo;
  logic [CNT_W-1:0]   op_hi;
  logic [1:0]         res_status;
  logic [FRAME_W-1:0] res_frame;
  logic [CNT_W-1:0]   free_count;
  logic [CNT_W-1:0]   used_count;
  logic [FRAME_W-1:0] next_hint;
  logic [CNT_W-1:0]   frame_total;

  // Word evaluation unit signals.
  logic [CNT_W-1:0]   total_eff;
  logic [CNT_W-1:0]   total_m1;
  logic [WORD_AW-1:0] last_word;
  logic [CNT_W-1:0]   base;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  in_mask;
  logic [WORD_W-1:0]  lo_mask;
  logic [WORD_W-1:0]  hi_mask;
  logic [WORD_W-1:0]  one_mask;
  logic [WORD_W-1:0]  one_cand;
  logic [OFFC_W-1:0]  one_j;
  logic [CNT_W-1:0]   one_frame;
  logic [CNT_W-1:0]   one_hint;
  logic [WORD_W-1:0]  run_w;
  logic [WORD_W-1:0]  pw [OFFC_W];
  logic [WORD_W-1:0]  run_end;
  logic [OFFC_W-1:0]  run_sh;
  logic [OFFC_W-1:0]  t0;
  logic [OFFC_W-1:0]  lead;
  logic               pre_hit;
  logic               int_hit;
  logic [CNT_W-1:0]   end_j;
  logic [CNT_W-1:0]   run_first;
  logic               set_mode;
  logic [WORD_W-1:0]  rng_mask;
  logic [WORD_W-1:0]  rng_changed;
  logic [WORD_W-1:0]  rng_word;
  logic [CNT_W-1:0]   rng_n;
  logic               rng_last;
  logic [CNT_W-1:0]   req_need;
  logic [CNT_W:0]     req_sum;
  logic [CNT_W-1:0]   req_hi;
  logic [CNT_W-1:0]   req_hint;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    total_eff = (frame_total > TOTAL_RST) ? TOTAL_RST : frame_total;
    total_m1  = total_eff - 1'b1;
    last_word = total_m1[FRAME_W-1:OFF_W];
    base      = {1'b0, cur, {OFF_W{1'b0}}};
    word      = vld_q ? mem_q : '0;
    in_mask   = lo_bits(rel_off(total_eff, base));
    lo_mask   = lo_bits(rel_off(op_lo, base));
    hi_mask   = lo_bits(rel_off(op_hi, base));

    // Single allocation: the start word is visited first for bits at or above
    // the hint and, after the wrap, once more for the bits below it.
    if (cur == op_lo[FRAME_W-1:OFF_W]) begin
      one_mask = phase ? (in_mask & lo_mask) : (in_mask & ~lo_mask);
    end else begin
      one_mask = in_mask;
    end
    one_cand  = word & one_mask;
    one_j     = first_set(one_cand);
    one_frame = base + CNT_W'(one_j);
    one_hint  = (one_frame + 1'b1 >= total_eff) ? '0 : one_frame + 1'b1;

    // Run search: bit j of run_end is set when a run of op_need free frames
    // ends at bit j inside this word; runs that began in earlier words are
    // covered by the carried run length.
    run_w = word & in_mask;
    pw[0] = run_w;
    for (int b = 1; b < OFFC_W; b++) begin
      pw[b] = pw[b-1] & (pw[b-1] << (1 << (b - 1)));
    end
    run_end = {WORD_W{1'b1}};
    run_sh  = '0;
    for (int b = 0; b < OFFC_W; b++) begin
      if (op_need[b]) begin
        run_end = run_end & (pw[b] << run_sh);
        run_sh  = run_sh + OFFC_W'(1 << b);
      end
    end
    t0   = first_set(~run_w);
    lead = OFFC_W'(WORD_W);
    for (int j = 0; j < WORD_W; j++) begin
      if (!run_w[j]) lead = OFFC_W'(WORD_W - 1 - j);
    end
    pre_hit   = (carry + CNT_W'(t0)) >= op_need;
    int_hit   = (op_need <= CNT_W'(WORD_W)) && (|run_end);
    end_j     = pre_hit ? (op_need - carry - 1'b1) : CNT_W'(first_set(run_end));
    run_first = base + end_j + 1'b1 - op_need;

    // Range update for run free, marks and the clearing pass of a run allocation.
    set_mode    = (op_kind == KIND_FREE_RUN) || (op_kind == KIND_MARK_USE);
    rng_mask    = hi_mask & ~lo_mask;
    rng_changed = set_mode ? (rng_mask & ~word) : (rng_mask & word);
    rng_word    = set_mode ? (word | rng_mask) : (word & ~rng_mask);
    rng_n       = '0;
    for (int j = 0; j < WORD_W; j++) begin
      rng_n = rng_n + CNT_W'(rng_changed[j]);
    end
    rng_last = ((op_hi - 1'b1) >> OFF_W) == CNT_W'(cur);

    // Request decode.
    req_need = (frame_count == '0) ? CNT_W'(1) : frame_count;
    req_sum  = {2'b00, start_frame} + {1'b0, frame_count};
    req_hi   = (req_sum > {1'b0, total_eff}) ? total_eff : req_sum[CNT_W-1:0];
    req_hint = ({1'b0, next_hint} < total_eff) ? {1'b0, next_hint} : '0;

    // Bitmap write of the current word.
    wr_en   = 1'b0;
    wr_data = rng_word;
    if (state == S_EV) begin
      case (op_kind)
        KIND_ALLOC_ONE: begin
          wr_en   = |one_cand;
          wr_data = word & ~(WORD_W'(1) << one_j[OFF_W-1:0]);
        end
        KIND_ALLOC_RUN: begin
          wr_en = clearing;
        end
        KIND_FREE_ONE: begin
          wr_en   = !word[op_start[OFF_W-1:0]];
          wr_data = word | (WORD_W'(1) << op_start[OFF_W-1:0]);
        end
        KIND_FREE_RUN, KIND_MARK_USE, KIND_MARK_RESV: begin
          wr_en = 1'b1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_ok <= '0;
    end else if (wr_en) begin
      word_ok[cur] <= 1'b1;
    end
    if (wr_en) begin
      free_map[cur] <= wr_data;
    end
    if (state == S_RD) begin
      mem_q <= free_map[cur];
      vld_q <= word_ok[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      free_count  <= '0;
      used_count  <= '0;
      next_hint   <= '0;
      frame_total <= TOTAL_RST;
      phase       <= 1'b0;
      clearing    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_total <= cfg_data;
      end
      // In S_OUT the result register is reloaded instead when it is taken.
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_kind    <= kind;
            op_start   <= start_frame;
            res_frame  <= '0;
            res_status <= ST_DONE;
            phase      <= 1'b0;
            clearing   <= 1'b0;
            carry      <= '0;
            case (kind)
              KIND_ALLOC_ONE: begin
                op_lo <= req_hint;
                cur   <= req_hint[FRAME_W-1:OFF_W];
                if (total_eff == '0) begin
                  res_status <= ST_NOFREE;
                  state      <= S_OUT;
                end else begin
                  state <= S_RD;
                end
              end
              KIND_ALLOC_RUN: begin
                op_need <= req_need;
                cur     <= '0;
                if (req_need > total_eff) begin
                  res_status <= ST_NOFREE;
                  state      <= S_OUT;
                end else begin
                  state <= S_RD;
                end
              end
              KIND_FREE_ONE: begin
                cur <= start_frame[FRAME_W-1:OFF_W];
                if ({1'b0, start_frame} >= total_eff) begin
                  res_status <= ST_INVALID;
                  state      <= S_OUT;
                end else begin
                  state <= S_RD;
                end
              end
              KIND_FREE_RUN, KIND_MARK_USE, KIND_MARK_RESV: begin
                op_lo <= {1'b0, start_frame};
                op_hi <= req_hi;
                cur   <= start_frame[FRAME_W-1:OFF_W];
                state <= ({1'b0, start_frame} >= req_hi) ? S_OUT : S_RD;
              end
              default: begin
                res_status <= ST_INVALID;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          state <= S_RD;
          case (op_kind)
            KIND_ALLOC_ONE: begin
              if (|one_cand) begin
                free_count <= sat_dec(free_count, CNT_W'(1));
                used_count <= sat_inc(used_count, CNT_W'(1), total_eff);
                next_hint  <= one_hint[FRAME_W-1:0];
                res_frame  <= one_frame[FRAME_W-1:0];
                state      <= S_OUT;
              end else if (phase && cur == op_lo[FRAME_W-1:OFF_W]) begin
                res_status <= ST_NOFREE;
                state      <= S_OUT;
              end else if (cur == last_word) begin
                cur   <= '0;
                phase <= 1'b1;
              end else begin
                cur <= cur + 1'b1;
              end
            end
            KIND_ALLOC_RUN: begin
              if (clearing) begin
                free_count <= sat_dec(free_count, rng_n);
                used_count <= sat_inc(used_count, rng_n, total_eff);
                if (rng_last) begin
                  state <= S_OUT;
                end else begin
                  cur <= cur + 1'b1;
                end
              end else if (pre_hit || int_hit) begin
                clearing  <= 1'b1;
                op_lo     <= run_first;
                op_hi     <= run_first + op_need;
                res_frame <= run_first[FRAME_W-1:0];
                cur       <= run_first[FRAME_W-1:OFF_W];
              end else if (cur == last_word) begin
                res_status <= ST_NOFREE;
                state      <= S_OUT;
              end else begin
                carry <= (&run_w) ? carry + CNT_W'(WORD_W) : CNT_W'(lead);
                cur   <= cur + 1'b1;
              end
            end
            KIND_FREE_ONE: begin
              if (word[op_start[OFF_W-1:0]]) begin
                res_status <= ST_INVALID;
              end else begin
                free_count <= sat_inc(free_count, CNT_W'(1), total_eff);
                used_count <= sat_dec(used_count, CNT_W'(1));
              end
              state <= S_OUT;
            end
            KIND_FREE_RUN, KIND_MARK_USE, KIND_MARK_RESV: begin
              if (op_kind == KIND_MARK_RESV) begin
                free_count <= sat_dec(free_count, rng_n);
              end else begin
                free_count <= sat_inc(free_count, rng_n, total_eff);
              end
              if (op_kind == KIND_FREE_RUN) begin
                used_count <= sat_dec(used_count, rng_n);
              end
              if (rng_last) begin
                state <= S_OUT;
              end else begin
                cur <= cur + 1'b1;
              end
            end
            default: begin
              res_status <= ST_INVALID;
              state      <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            result_frame <= res_frame;
            free_total   <= free_count;
            used_total   <= used_count;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/bfa_checker.sv @@
// ---------------------------------------------------------------------------
// bfa_props
// Port-level checks on the frame allocator, bound to the top level.
// ---------------------------------------------------------------------------
module bfa_props
  import bfa_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic [FRAME_W-1:0] result_frame,
  input logic [CNT_W-1:0]   free_total,
  input logic [CNT_W-1:0]   used_total
);

  // A result waiting to be taken holds its transaction unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_frame))
    else $error("result changed while stalled");

  // The engine handles one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a request while busy");

  // Only a successful allocation reports a frame.
  a_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> result_frame == '0)
    else $error("frame reported without allocation");

  // Counts never pass the number of frames managed.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> free_total <= CNT_W'(FRAMES) && used_total <= CNT_W'(FRAMES))
    else $error("count out of range");

endmodule

bind bitmap_frame_allocator_top bfa_props u_bfa_checker (.*);
